// ===== rtl/core/matrix4_inverse_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix inverse unit
// Both macros expect clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_INVERSE_UNIT_MACROS_SVH
`define MATRIX4_INVERSE_UNIT_MACROS_SVH

// Same-cycle implication.
`define M4I_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("m4i assertion failed");

// Next-cycle implication.
`define M4I_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("m4i assertion failed");

`endif

// ===== rtl/core/m4i_pkg.sv =====
// ----------------------------------------------------------------------------
// m4i_pkg
// Types and the term decoder that drives the cofactor sequencer.
// ----------------------------------------------------------------------------
package m4i_pkg;

  typedef enum logic [1:0] {
    SRC_ELEM  = 2'd0,
    SRC_MINOR = 2'd1,
    SRC_COF   = 2'd2
  } src_e;

  // One multiply-accumulate term: acc += (+/-) elem[ea] * source[sidx].
  typedef struct packed {
    logic [3:0] ea;
    src_e       src;
    logic [3:0] sidx;
    logic       neg;
    logic       last;
  } term_t;

  localparam logic [4:0] NUM_MINOR_GRP = 5'd12;
  localparam logic [4:0] DET_GRP       = 5'd28;

  function automatic logic [3:0] pair_idx(input logic [1:0] x, input logic [1:0] y);
    logic [3:0] r;
    case ({x, y})
      4'b0001: r = 4'd0;
      4'b0010: r = 4'd1;
      4'b0011: r = 4'd2;
      4'b0110: r = 4'd3;
      4'b0111: r = 4'd4;
      4'b1011: r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Groups 0..11 are the 2x2 minors (rows 0/1, then rows 2/3), groups 12..27
  // the cofactors in row-major order, group 28 the determinant.
  function automatic term_t term_decode(input logic [4:0] grp, input logic [1:0] trm);
    term_t      d;
    logic [2:0] p;
    logic [1:0] a, b, r0, r, c, o, x0, x1, x2, jp, ya, yb;
    logic [3:0] i, off;
    d = '0;
    if (grp < NUM_MINOR_GRP) begin
      p  = (grp >= 5'd6) ? 3'(grp - 5'd6) : grp[2:0];
      r0 = (grp >= 5'd6) ? 2'd2 : 2'd0;
      case (p)
        3'd0:    begin a = 2'd0; b = 2'd1; end
        3'd1:    begin a = 2'd0; b = 2'd2; end
        3'd2:    begin a = 2'd0; b = 2'd3; end
        3'd3:    begin a = 2'd1; b = 2'd2; end
        3'd4:    begin a = 2'd1; b = 2'd3; end
        default: begin a = 2'd2; b = 2'd3; end
      endcase
      d.src = SRC_ELEM;
      if (trm == 2'd0) begin
        d.ea   = {r0, a};
        d.sidx = {r0 + 2'd1, b};
      end else begin
        d.ea   = {r0, b};
        d.sidx = {r0 + 2'd1, a};
        d.neg  = 1'b1;
        d.last = 1'b1;
      end
    end else if (grp < DET_GRP) begin
      i   = 4'(grp - NUM_MINOR_GRP);
      r   = i[3:2];
      c   = i[1:0];
      o   = r ^ 2'd1;
      off = r[1] ? 4'd0 : 4'd6;
      x0  = (c == 2'd0) ? 2'd1 : 2'd0;
      x1  = (c <= 2'd1) ? 2'd2 : 2'd1;
      x2  = (c <= 2'd2) ? 2'd3 : 2'd2;
      case (trm)
        2'd0:    begin jp = x0; ya = x1; yb = x2; end
        2'd1:    begin jp = x1; ya = x0; yb = x2; end
        default: begin jp = x2; ya = x0; yb = x1; end
      endcase
      d.src  = SRC_MINOR;
      d.ea   = {o, jp};
      d.sidx = off + pair_idx(ya, yb);
      d.neg  = (trm == 2'd1) ^ r[0] ^ c[0];
      d.last = (trm == 2'd2);
    end else begin
      d.src  = SRC_COF;
      d.ea   = {2'd0, trm};
      d.sidx = {2'd0, trm};
      d.last = (trm == 2'd3);
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/m4i_in_if.sv =====
// ----------------------------------------------------------------------------
// m4i_in_if
// Element channel: one matrix element per beat.
// ----------------------------------------------------------------------------
interface m4i_in_if #(parameter int WORD_BITS = 32) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

// ===== rtl/core/m4i_out_if.sv =====
// ----------------------------------------------------------------------------
// m4i_out_if
// Result channel: one inverse element per beat, with status flags.
// ----------------------------------------------------------------------------
interface m4i_out_if #(parameter int WORD_BITS = 32) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] inverse_value;
  logic                        last_element;
  logic                        singular;
  logic                        overflow;

  modport source (output valid, output inverse_value, output last_element,
                  output singular, output overflow, input ready);
  modport sink (input valid, input inverse_value, input last_element,
                input singular, input overflow, output ready);
endinterface

// ===== rtl/core/matrix4_inverse_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_inverse_unit
// 4x4 fixed-point matrix inverse by cofactors and adjugate.
//
//   channel  dir  payload                                    beats/matrix
//   elem_in  in   element_value                              16
//   inv_out  out  inverse_value, last_element, singular,     16
//                 overflow
//
// Sixteen beats load the matrix, one per cycle. The solve then runs 76
// multiply-accumulate terms on one shift-add multiplier, followed by one
// restoring divider pass per result element unless the matrix is singular.
// elem_in is ready only while loading. Each result waits in its register
// until taken; a stalled output holds the divider.
// Reset clears the sequencer and the load count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "matrix4_inverse_unit_macros.svh"

module matrix4_inverse_unit
  import m4i_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  m4i_in_if.sink    elem_in,
  m4i_out_if.source inv_out
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int MW   = 2 * W + 1;
  localparam int CW   = 3 * W + 3;
  localparam int AW   = 4 * W + 5;
  localparam int NW   = CW + 2 * F;
  localparam int RW   = (NW > AW + W) ? NW : AW + W;
  localparam int CNTW = $clog2(W + 1);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_RDA  = 4'd1;
  localparam logic [3:0] ST_RDB  = 4'd2;
  localparam logic [3:0] ST_MSET = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_DMAG = 4'd5;
  localparam logic [3:0] ST_DSET = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [3:0]      load_q;
  logic [4:0]      grp_q;
  logic [1:0]      trm_q;
  logic [CNTW-1:0] cnt_q;
  logic [3:0]      k_q;

  logic [W-1:0]    elem_mem [16];
  logic [W-1:0]    elem_rd_q;
  logic [3:0]      rd_addr;

  logic [W-1:0]    mul_q;
  logic [AW-1:0]   msh_q, acc_q, addend, acc_sum;
  logic [MW-1:0]   minor_q [12];
  logic [CW-1:0]   cof_q [16];
  logic [AW-1:0]   dmag_q;
  logic            sing_q, dneg_q, nneg_q;
  logic [RW-1:0]   rem_q, dsh_q;
  logic [RW:0]     diff;
  logic [W:0]      quo_q;
  logic [W-1:0]    val_q;
  logic            ovf_q;

  term_t           dec;
  logic            in_fire, out_fire, mul_end, div_end, sub_now;
  logic [3:0]      ci;
  logic [CW-1:0]   num, nabs;
  logic            rneg;
  logic [W-1:0]    lim, lo;
  logic            ovf_now;

  assign dec      = term_decode(grp_q, trm_q);
  assign in_fire  = elem_in.valid && elem_in.ready;
  assign out_fire = inv_out.valid && inv_out.ready;
  assign mul_end  = (state_q == ST_MUL) && (cnt_q == CNTW'(W - 1));
  assign div_end  = (state_q == ST_DIV) && (cnt_q == CNTW'(W));

  assign elem_in.ready         = (state_q == ST_LOAD);
  assign inv_out.valid         = (state_q == ST_OUT);
  assign inv_out.inverse_value = val_q;
  assign inv_out.last_element  = (k_q == 4'd15);
  assign inv_out.singular      = sing_q;
  assign inv_out.overflow      = ovf_q;

  always_comb begin
    case (state_q)
      ST_RDA:  rd_addr = dec.ea;
      ST_RDB:  rd_addr = dec.sidx;
      default: rd_addr = load_q;
    endcase
  end

  // Shift-add multiplier: the top multiplier bit carries negative weight.
  assign sub_now = (cnt_q == CNTW'(W - 1)) ^ dec.neg;
  assign addend  = mul_q[0] ? (sub_now ? (~msh_q + AW'(1)) : msh_q) : '0;
  assign acc_sum = acc_q + addend;

  assign diff = {1'b0, rem_q} - {1'b0, dsh_q};

  // Adjugate entry (row k, col j) is the cofactor at (j, k).
  assign ci   = {k_q[1:0], k_q[3:2]};
  assign num  = cof_q[ci];
  assign nabs = num[CW-1] ? (~num + CW'(1)) : num;

  assign rneg    = nneg_q ^ dneg_q;
  assign lim     = rneg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
  assign ovf_now = quo_q[W] || (quo_q[W-1:0] > lim);
  assign lo      = ovf_now ? lim : quo_q[W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (in_fire && load_q == 4'd15) state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_MSET;
      ST_MSET: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_end) begin
          state_d = (dec.last && grp_q == DET_GRP) ? ST_DMAG : ST_RDA;
        end
      end
      ST_DMAG: state_d = ST_DSET;
      ST_DSET: state_d = sing_q ? ST_OUT : ST_DIV;
      ST_DIV:  if (div_end) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_fire) state_d = (k_q == 4'd15) ? ST_LOAD : ST_DSET;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      load_q  <= '0;
      grp_q   <= '0;
      trm_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) load_q <= load_q + 4'd1;
      case (state_q)
        ST_LOAD: begin
          grp_q <= '0;
          trm_q <= '0;
        end
        ST_MSET: cnt_q <= '0;
        ST_MUL: begin
          cnt_q <= cnt_q + CNTW'(1);
          if (mul_end) begin
            if (dec.last) begin
              grp_q <= grp_q + 5'd1;
              trm_q <= '0;
            end else begin
              trm_q <= trm_q + 2'd1;
            end
          end
        end
        ST_DMAG: k_q <= '0;
        ST_DSET: cnt_q <= '0;
        ST_DIV:  cnt_q <= cnt_q + CNTW'(1);
        ST_OUT:  if (out_fire) k_q <= k_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) elem_mem[load_q] <= elem_in.element_value;
    elem_rd_q <= elem_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: acc_q <= '0;
      ST_RDB:  mul_q <= elem_rd_q;
      ST_MSET: begin
        case (dec.src)
          SRC_ELEM:  msh_q <= {{(AW - W){elem_rd_q[W-1]}}, elem_rd_q};
          SRC_MINOR: msh_q <= {{(AW - MW){minor_q[dec.sidx][MW-1]}}, minor_q[dec.sidx]};
          SRC_COF:   msh_q <= {{(AW - CW){cof_q[dec.sidx][CW-1]}}, cof_q[dec.sidx]};
          default:   msh_q <= '0;
        endcase
      end
      ST_MUL: begin
        mul_q <= mul_q >> 1;
        msh_q <= msh_q << 1;
        if (mul_end && dec.last) begin
          acc_q <= '0;
          if (grp_q < NUM_MINOR_GRP) begin
            minor_q[grp_q[3:0]] <= acc_sum[MW-1:0];
          end else if (grp_q < DET_GRP) begin
            cof_q[4'(grp_q - NUM_MINOR_GRP)] <= acc_sum[CW-1:0];
          end else begin
            dmag_q <= acc_sum;
          end
        end else begin
          acc_q <= acc_sum;
        end
      end
      ST_DMAG: begin
        sing_q <= (dmag_q == '0);
        dneg_q <= dmag_q[AW-1];
        if (dmag_q[AW-1]) dmag_q <= ~dmag_q + AW'(1);
      end
      ST_DSET: begin
        nneg_q <= num[CW-1];
        rem_q  <= RW'({nabs, {(2 * F){1'b0}}});
        dsh_q  <= RW'({dmag_q, {W{1'b0}}});
        quo_q  <= '0;
        val_q  <= '0;
        ovf_q  <= 1'b0;
      end
      ST_DIV: begin
        if (!diff[RW]) rem_q <= diff[RW-1:0];
        quo_q <= {quo_q[W-1:0], !diff[RW]};
        dsh_q <= dsh_q >> 1;
      end
      ST_FIN: begin
        val_q <= rneg ? (~lo + W'(1)) : lo;
        ovf_q <= ovf_now;
      end
      default: ;
    endcase
  end

  `M4I_ASSERT_NOW(a_no_overlap, elem_in.ready, !inv_out.valid)
  `M4I_ASSERT_NOW(a_singular_zero, inv_out.valid && inv_out.singular, inv_out.inverse_value == '0 && !inv_out.overflow)
  `M4I_ASSERT_NEXT(a_solve_start, in_fire && load_q == 4'd15, state_q == ST_RDA && grp_q == '0 && trm_q == '0)
  `M4I_ASSERT_NEXT(a_back_to_load, out_fire && inv_out.last_element, state_q == ST_LOAD && load_q == '0)

endmodule
